// File: rtl/core/sqos_pkg.sv
`timescale 1ns / 1ps

package sqos_pkg;

  // Fixed field widths of the two channels.
  localparam int OPCODE_W = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Opcodes; the codes above OP_SWAP carry no meaning.
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH = 3'd0,
    OP_PALL = 3'd1,
    OP_PINT = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } op_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_SHORT = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    latch_in;
    logic    push;
    logic    pop;
    logic    rd_top;
    logic    pall_start;
    logic    pall_step;
    logic    swap_wr_a;
    logic    swap_wr_b;
    logic    out_load;
    logic    out_from_mem;
    logic    out_last;
    status_t out_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic too_short;
    logic out_free;
    logic walk_last;
  } dp_stat_t;

endpackage

// File: rtl/core/sqos_in_if.sv
`timescale 1ns / 1ps

interface sqos_in_if;
  logic                                valid;
  logic                                ready;
  logic [sqos_pkg::OPCODE_W-1:0]       opcode;
  logic signed [sqos_pkg::DATA_W-1:0]  push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink (input valid, input opcode, input push_value, output ready);
endinterface

// File: rtl/core/sqos_out_if.sv
`timescale 1ns / 1ps

interface sqos_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sqos_pkg::DATA_W-1:0]  data;
  logic                                data_valid;
  logic [sqos_pkg::STATUS_W-1:0]       status;
  logic                                last;

  modport source (output valid, output data, output data_valid, output status,
                  output last, input ready);
  modport sink (input valid, input data, input data_valid, input status,
                input last, output ready);
endinterface

// File: rtl/core/sqos_ctrl.sv
`timescale 1ns / 1ps

module sqos_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [sqos_pkg::OPCODE_W-1:0] in_opcode,
  output logic                          in_ready,
  input  sqos_pkg::dp_stat_t            stat,
  output sqos_pkg::dp_cmd_t             cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RESP,
    S_PEEK,
    S_SWAP_A,
    S_SWAP_B,
    S_PALL
  } state_t;

  state_t              state_r, state_nxt;
  sqos_pkg::op_t       op_r, op_nxt;
  sqos_pkg::status_t   st_r, st_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    st_nxt    = st_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          op_nxt       = sqos_pkg::op_t'(in_opcode);
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_RESP;
        st_nxt    = sqos_pkg::ST_OK;
        unique case (op_r)
          sqos_pkg::OP_PUSH: begin
            if (stat.full) begin
              st_nxt = sqos_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          sqos_pkg::OP_PINT: begin
            if (stat.empty) begin
              st_nxt = sqos_pkg::ST_EMPTY;
            end else begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_PEEK;
            end
          end
          sqos_pkg::OP_POP: begin
            if (stat.empty) begin
              st_nxt = sqos_pkg::ST_EMPTY;
            end else begin
              cmd.pop = 1'b1;
            end
          end
          sqos_pkg::OP_SWAP: begin
            if (stat.too_short) begin
              st_nxt = sqos_pkg::ST_SHORT;
            end else begin
              cmd.rd_top = 1'b1;
              state_nxt  = S_SWAP_A;
            end
          end
          sqos_pkg::OP_PALL: begin
            if (!stat.empty) begin
              cmd.pall_start = 1'b1;
              state_nxt      = S_PALL;
            end
          end
          default: begin
            st_nxt = sqos_pkg::ST_OK;
          end
        endcase
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = st_r;
          cmd.out_last   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_PEEK: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_SWAP_A: begin
        cmd.swap_wr_a = 1'b1;
        state_nxt     = S_SWAP_B;
      end
      S_SWAP_B: begin
        cmd.swap_wr_b = 1'b1;
        st_nxt        = sqos_pkg::ST_OK;
        state_nxt     = S_RESP;
      end
      S_PALL: begin
        if (stat.out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_last     = stat.walk_last;
          if (stat.walk_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pall_step = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and latched opcode and status.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= sqos_pkg::OP_PUSH;
      st_r    <= sqos_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

// File: rtl/core/sqos_dp.sv
`timescale 1ns / 1ps

module sqos_dp #(
  parameter int DEPTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic signed [sqos_pkg::DATA_W-1:0]  push_value,
  input  sqos_pkg::dp_cmd_t                   cmd,
  output sqos_pkg::dp_stat_t                  stat,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [sqos_pkg::DATA_W-1:0]  out_data,
  output logic                                out_data_valid,
  output logic [sqos_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_last
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST_SLOT = IW'(DEPTH - 1);
  localparam logic [CW:0]   DEPTH_W   = (CW + 1)'(DEPTH);

  logic [sqos_pkg::DATA_W-1:0]        mem [DEPTH];
  logic [sqos_pkg::DATA_W-1:0]        rd_a_r, rd_b_r;
  logic signed [sqos_pkg::DATA_W-1:0] val_r;
  logic [IW-1:0]                      top_r, walk_r;
  logic [CW-1:0]                      count_r, rem_r;
  logic                               queue_mode_r;

  logic                               out_valid_r;
  logic signed [sqos_pkg::DATA_W-1:0] out_data_r;
  logic                               out_dv_r;
  sqos_pkg::status_t                  out_status_r;
  logic                               out_last_r;

  logic [IW-1:0]               top_up, top_down, walk_down, push_addr, bottom_gap;
  logic [CW:0]                 gap_diff, gap_sum;
  logic                        wr_en, rd_a_en;
  logic [IW-1:0]               wr_addr, rd_a_addr;
  logic [sqos_pkg::DATA_W-1:0] wr_data;

  // Neighbouring slots on the circular buffer.
  assign top_up    = (top_r == LAST_SLOT) ? '0 : top_r + IW'(1);
  assign top_down  = (top_r == '0) ? LAST_SLOT : top_r - IW'(1);
  assign walk_down = (walk_r == '0) ? LAST_SLOT : walk_r - IW'(1);

  // Free slot just below the bottom entry, for pushes in queue mode.
  assign gap_diff   = {1'b0, CW'(top_r)} - {1'b0, count_r};
  assign gap_sum    = gap_diff[CW] ? gap_diff + DEPTH_W : gap_diff;
  assign bottom_gap = gap_sum[IW-1:0];

  always_comb begin
    if (queue_mode_r) begin
      push_addr = bottom_gap;
    end else if (count_r != '0) begin
      push_addr = top_up;
    end else begin
      push_addr = top_r;
    end
  end

  // Write port: push, or the two halves of a swap.
  assign wr_en   = cmd.push | cmd.swap_wr_a | cmd.swap_wr_b;
  assign wr_addr = cmd.push ? push_addr : (cmd.swap_wr_a ? top_r : top_down);
  assign wr_data = cmd.push ? val_r : (cmd.swap_wr_a ? rd_b_r : rd_a_r);

  // Read port A serves peek, swap and the print-all walk; port B the entry below top.
  assign rd_a_en   = cmd.rd_top | cmd.pall_start | cmd.pall_step;
  assign rd_a_addr = cmd.pall_step ? walk_r : top_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_r <= mem[rd_a_addr];
    end
    if (cmd.rd_top) begin
      rd_b_r <= mem[top_down];
    end
  end

  // Pointer, count, walk and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r        <= '0;
      count_r      <= '0;
      walk_r       <= '0;
      rem_r        <= '0;
      queue_mode_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        queue_mode_r <= cfg_wr_data;
      end
      if (cmd.push) begin
        count_r <= count_r + CW'(1);
        if (!queue_mode_r && (count_r != '0)) begin
          top_r <= top_up;
        end
      end else if (cmd.pop) begin
        count_r <= count_r - CW'(1);
        if (count_r != CW'(1)) begin
          top_r <= top_down;
        end
      end
      if (cmd.pall_start) begin
        walk_r <= top_down;
        rem_r  <= count_r;
      end else if (cmd.pall_step) begin
        walk_r <= walk_down;
        rem_r  <= rem_r - CW'(1);
      end
    end
  end

  // Push value is captured with the transaction.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      val_r <= push_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r   <= cmd.out_from_mem ? rd_a_r : '0;
      out_dv_r     <= cmd.out_from_mem;
      out_status_r <= cmd.out_status;
      out_last_r   <= cmd.out_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_data_valid = out_dv_r;
  assign out_status     = out_status_r;
  assign out_last       = out_last_r;

  // Status back to the controller.
  assign stat.empty     = (count_r == '0);
  assign stat.full      = (count_r == CW'(DEPTH));
  assign stat.too_short = (count_r < CW'(2));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.walk_last = (rem_r == CW'(1));

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten before it was taken");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (count_r != CW'(DEPTH)))
    else $error("push executed on a full store");

  a_walk_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pall_step |-> (rem_r > CW'(1)))
    else $error("print-all walk stepped past the bottom entry");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.push && !cmd.pop && !cfg_wr_en) |=> $stable(count_r))
    else $error("entry count changed without push or pop");
`endif

endmodule

// File: rtl/core/stack_queue_operand_store_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload                               Transfer
// in_ch     sink       opcode[2:0], push_value[31:0] signed  valid & ready
// out_ch    source     data[31:0] signed, data_valid,         valid & ready
//                      status[1:0], last
// cfg_*     write      cfg_wr_data (queue mode)              cfg_wr_en
//
// Push, pop, peek and meaningless opcodes pass through decode, execute and
// result load before the next acceptance; swap inserts a write step for each half,
// as both halves go through the store's single write port.
// Print all walks the store after decode and execute, one read per cycle
// on read port A while the sink takes each result.
// Reset is synchronous; the value store has no reset and no clearing pass.
// A new transaction is accepted while the previous result still waits in the
// output register; a stalled sink holds the walk in place.

module stack_queue_operand_store_unit #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  sqos_in_if.sink     in_ch,
  sqos_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  sqos_pkg::dp_cmd_t  cmd;
  sqos_pkg::dp_stat_t stat;
  logic               in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer.
  sqos_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Store, pointers and output register.
  sqos_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .push_value     (in_ch.push_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_data       (out_ch.data),
    .out_data_valid (out_ch.data_valid),
    .out_status     (out_ch.status),
    .out_last       (out_ch.last)
  );

endmodule

// File: tb/tb_stack_queue_operand_store_unit.sv
`timescale 1ns / 1ps

module tb_stack_queue_operand_store_unit;

  localparam int STORE_DEPTH   = 64;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_LIMIT  = 10;

  // Opcodes with no meaning; the block must answer them with a plain OK.
  localparam logic [sqos_pkg::OPCODE_W-1:0] OP_SPARE_LO  = 3'd5;
  localparam logic [sqos_pkg::OPCODE_W-1:0] OP_SPARE_MID = 3'd6;
  localparam logic [sqos_pkg::OPCODE_W-1:0] OP_SPARE_HI  = 3'd7;

  localparam logic signed [sqos_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [sqos_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One result transaction as seen on the output channel.
  typedef struct packed {
    logic signed [sqos_pkg::DATA_W-1:0] data;
    logic                               data_valid;
    sqos_pkg::status_t                  status;
    logic                               last;
  } result_t;

  // One row of the opening sequence; typed rows carry their own answer.
  typedef struct packed {
    logic [sqos_pkg::OPCODE_W-1:0]      op;
    logic signed [sqos_pkg::DATA_W-1:0] value;
    logic                               typed;
    result_t                            want;
  } opening_row_t;

  localparam result_t R_DONE  = '{32'sd0, 1'b0, sqos_pkg::ST_OK, 1'b1};
  localparam result_t R_EMPTY = '{32'sd0, 1'b0, sqos_pkg::ST_EMPTY, 1'b1};
  localparam result_t R_SHORT = '{32'sd0, 1'b0, sqos_pkg::ST_SHORT, 1'b1};
  localparam result_t R_FULL  = '{32'sd0, 1'b0, sqos_pkg::ST_FULL, 1'b1};
  localparam result_t R_NONE  = '{32'sd0, 1'b0, sqos_pkg::ST_OK, 1'b0};

  // Opening sequence in stack mode: empty-store errors, spare opcodes, the
  // signed extremes, a swap with one and with two entries, then a full unwind.
  opening_row_t opening_rows [0:23] = '{
    '{sqos_pkg::OP_PINT, 32'sd0,  1'b1, R_EMPTY},
    '{sqos_pkg::OP_POP,  32'sd0,  1'b1, R_EMPTY},
    '{sqos_pkg::OP_SWAP, 32'sd0,  1'b1, R_SHORT},
    '{sqos_pkg::OP_PALL, 32'sd0,  1'b1, R_DONE},
    '{OP_SPARE_LO,       VAL_MAX, 1'b1, R_DONE},
    '{OP_SPARE_HI,       VAL_MIN, 1'b1, R_DONE},
    '{sqos_pkg::OP_PUSH, VAL_MAX, 1'b1, R_DONE},
    '{sqos_pkg::OP_SWAP, 32'sd0,  1'b1, R_SHORT},
    '{sqos_pkg::OP_PINT, 32'sd0,  1'b1, '{VAL_MAX, 1'b1, sqos_pkg::ST_OK, 1'b1}},
    '{sqos_pkg::OP_PUSH, VAL_MIN, 1'b1, R_DONE},
    '{sqos_pkg::OP_PINT, 32'sd0,  1'b1, '{VAL_MIN, 1'b1, sqos_pkg::ST_OK, 1'b1}},
    '{sqos_pkg::OP_SWAP, 32'sd0,  1'b1, R_DONE},
    '{sqos_pkg::OP_PALL, 32'sd0,  1'b0, R_NONE},
    '{sqos_pkg::OP_PUSH, -32'sd1, 1'b1, R_DONE},
    '{OP_SPARE_MID,      -32'sd1, 1'b1, R_DONE},
    '{sqos_pkg::OP_PUSH, 32'sd0,  1'b1, R_DONE},
    '{sqos_pkg::OP_PALL, 32'sd0,  1'b0, R_NONE},
    '{sqos_pkg::OP_POP,  32'sd0,  1'b1, R_DONE},
    '{sqos_pkg::OP_PINT, 32'sd0,  1'b0, R_NONE},
    '{sqos_pkg::OP_POP,  32'sd0,  1'b1, R_DONE},
    '{sqos_pkg::OP_POP,  32'sd0,  1'b1, R_DONE},
    '{sqos_pkg::OP_POP,  32'sd0,  1'b1, R_DONE},
    '{sqos_pkg::OP_POP,  32'sd0,  1'b1, R_EMPTY},
    '{sqos_pkg::OP_PALL, 32'sd0,  1'b1, R_DONE}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic cfg_wr_data;

  sqos_in_if  in_ch ();
  sqos_out_if out_ch ();

  stack_queue_operand_store_unit #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the operand store, kept as a circular buffer.
  logic signed [sqos_pkg::DATA_W-1:0] store_vals [STORE_DEPTH];
  int      top_slot     = 0;
  int      n_stored     = 0;
  logic    queue_mode_q = 1'b0;
  result_t fresh_results[$];
  result_t awaited_results[$];

  // Run statistics and error bookkeeping.
  int err_count      = 0;
  int n_items        = 0;
  int n_queue_items  = 0;
  int n_results      = 0;
  int n_full_refused = 0;
  int longest_walk   = 0;

  // Stimulus pacing; hold_request is shared with the output sink.
  bit send_steady  = 1'b0;
  int hold_request = 0;

  function automatic int slot_below(int p);
    return (p == 0) ? STORE_DEPTH - 1 : p - 1;
  endfunction

  function automatic int slot_above(int p);
    return (p + 1 >= STORE_DEPTH) ? 0 : p + 1;
  endfunction

  function automatic void note_result(logic signed [sqos_pkg::DATA_W-1:0] d, logic dv,
                                      sqos_pkg::status_t st, logic lst);
    fresh_results.push_back('{d, dv, st, lst});
  endfunction

  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, msg);
    end
  endfunction

  // Applies one opcode to the shadow store and lists the results it causes.
  function automatic void apply_opcode(logic [sqos_pkg::OPCODE_W-1:0] op,
                                       logic signed [sqos_pkg::DATA_W-1:0] val);
    int p;
    int q;
    logic signed [sqos_pkg::DATA_W-1:0] held;
    fresh_results.delete();
    case (op)
      sqos_pkg::OP_PUSH: begin
        if (n_stored >= STORE_DEPTH) begin
          n_full_refused++;
          note_result('0, 1'b0, sqos_pkg::ST_FULL, 1'b1);
        end else begin
          if (!queue_mode_q) begin
            if (n_stored != 0) top_slot = slot_above(top_slot);
            store_vals[top_slot] = val;
          end else begin
            // The slot just below the bottom entry.
            p = (top_slot + STORE_DEPTH - n_stored) % STORE_DEPTH;
            store_vals[p] = val;
          end
          n_stored++;
          note_result('0, 1'b0, sqos_pkg::ST_OK, 1'b1);
        end
      end
      sqos_pkg::OP_PALL: begin
        if (n_stored == 0) begin
          note_result('0, 1'b0, sqos_pkg::ST_OK, 1'b1);
        end else begin
          p = top_slot;
          for (int k = 0; k < n_stored; k++) begin
            note_result(store_vals[p], 1'b1, sqos_pkg::ST_OK, k == n_stored - 1);
            p = slot_below(p);
          end
          if (n_stored > longest_walk) longest_walk = n_stored;
        end
      end
      sqos_pkg::OP_PINT: begin
        if (n_stored == 0) note_result('0, 1'b0, sqos_pkg::ST_EMPTY, 1'b1);
        else note_result(store_vals[top_slot], 1'b1, sqos_pkg::ST_OK, 1'b1);
      end
      sqos_pkg::OP_POP: begin
        if (n_stored == 0) begin
          note_result('0, 1'b0, sqos_pkg::ST_EMPTY, 1'b1);
        end else begin
          n_stored--;
          if (n_stored != 0) top_slot = slot_below(top_slot);
          note_result('0, 1'b0, sqos_pkg::ST_OK, 1'b1);
        end
      end
      sqos_pkg::OP_SWAP: begin
        if (n_stored < 2) begin
          note_result('0, 1'b0, sqos_pkg::ST_SHORT, 1'b1);
        end else begin
          p = top_slot;
          q = slot_below(top_slot);
          held = store_vals[p];
          store_vals[p] = store_vals[q];
          store_vals[q] = held;
          note_result('0, 1'b0, sqos_pkg::ST_OK, 1'b1);
        end
      end
      default: note_result('0, 1'b0, sqos_pkg::ST_OK, 1'b1);
    endcase
  endfunction

  // Sender gap: mostly none, sometimes short, now and then long.
  function automatic int pick_gap();
    int r;
    if (send_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Push values lean on the signed extremes and the all-zero/all-one patterns.
  function automatic logic signed [sqos_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 11))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Offers one transaction, waits for its acceptance and records what it must cause.
  task automatic offer(logic [sqos_pkg::OPCODE_W-1:0] op,
                       logic signed [sqos_pkg::DATA_W-1:0] val,
                       logic typed, result_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.push_value <= val;
    do @(posedge clk); while (!in_ch.ready);
    apply_opcode(op, val);
    if (typed) begin
      awaited_results.push_back(want);
    end else begin
      foreach (fresh_results[i]) awaited_results.push_back(fresh_results[i]);
    end
    n_items++;
    if (queue_mode_q) n_queue_items++;
  endtask

  // Stops offering and waits until every awaited result has been taken.
  task automatic settle_inputs();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_queue_mode(logic mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    queue_mode_q  = mode;
  endtask

  // Random traffic in stretches that lean towards filling, balancing or draining.
  task automatic run_mix(int n_ops);
    int push_pct;
    int r;
    logic [sqos_pkg::OPCODE_W-1:0] op;
    push_pct = 35;
    for (int i = 0; i < n_ops; i++) begin
      if (i % 25 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 65;
          1:       push_pct = 35;
          default: push_pct = 15;
        endcase
        send_steady = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct) begin
        op = sqos_pkg::OP_PUSH;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) op = sqos_pkg::OP_PALL;
        else if (r < 30) op = sqos_pkg::OP_PINT;
        else if (r < 50) op = sqos_pkg::OP_SWAP;
        else if (r < 57) op = sqos_pkg::OPCODE_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else op = sqos_pkg::OP_POP;
      end
      offer(op, random_value(), 1'b0, R_NONE);
    end
    send_steady = 1'b0;
  endtask

  // Compares one accepted result transaction with the oldest awaited one.
  task automatic take_result();
    result_t got;
    result_t oldest;
    got = '{out_ch.data, out_ch.data_valid, sqos_pkg::status_t'(out_ch.status),
            out_ch.last};
    n_results++;
    if (awaited_results.size() == 0) begin
      note_failure($sformatf("Unexpected result: data=%0d valid=%0b status=%0d last=%0b",
                             got.data, got.data_valid, got.status, got.last));
    end else begin
      oldest = awaited_results.pop_front();
      if (got.data !== oldest.data || got.data_valid !== oldest.data_valid ||
          got.status !== oldest.status || got.last !== oldest.last) begin
        note_failure($sformatf({"Result %0d mismatch: expected data=%0d valid=%0b ",
                                "status=%0d last=%0b, got data=%0d valid=%0b status=%0d ",
                                "last=%0b"},
                               n_results, oldest.data, oldest.data_valid, oldest.status,
                               oldest.last, got.data, got.data_valid, got.status, got.last));
      end
    end
  endtask

  // Output sink: random ready with short and long stalls, calm stretches and
  // the long hold-off asked for by the stimulus.
  initial begin
    int stall_left;
    int cyc;
    bit sink_steady;
    stall_left  = 0;
    cyc         = 0;
    sink_steady = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else begin
        if (out_ch.valid && out_ch.ready) take_result();
        cyc++;
        if (cyc % 64 == 0) sink_steady = ($urandom_range(0, 3) == 0);
        if (hold_request > 0) begin
          stall_left   = hold_request;
          hold_request = 0;
        end
        if (stall_left > 0) begin
          out_ch.ready <= 1'b0;
          stall_left--;
        end else if (sink_steady || $urandom_range(0, 99) < 60) begin
          out_ch.ready <= 1'b1;
        end else begin
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 3);
          out_ch.ready <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  // Main stimulus sequence.
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= sqos_pkg::OP_PUSH;
    in_ch.push_value <= '0;
    cfg_wr_en        <= 1'b0;
    cfg_wr_data      <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    set_queue_mode(1'b0);
    foreach (opening_rows[i]) begin
      offer(opening_rows[i].op, opening_rows[i].value, opening_rows[i].typed,
            opening_rows[i].want);
    end
    settle_inputs();

    // Fill the store in queue mode while the sink holds off, so the block
    // backs up and stalls its input; then refuse pushes, swap, peek and walk all entries.
    set_queue_mode(1'b1);
    send_steady  = 1'b1;
    hold_request = HOLD_CYCLES;
    while (n_stored < STORE_DEPTH) offer(sqos_pkg::OP_PUSH, random_value(), 1'b0, R_NONE);
    repeat (3) offer(sqos_pkg::OP_PUSH, random_value(), 1'b1, R_FULL);
    offer(sqos_pkg::OP_SWAP, random_value(), 1'b0, R_NONE);
    offer(sqos_pkg::OP_PINT, random_value(), 1'b0, R_NONE);
    offer(sqos_pkg::OP_PALL, random_value(), 1'b0, R_NONE);
    send_steady = 1'b0;
    settle_inputs();

    run_mix(120);
    settle_inputs();
    set_queue_mode(1'b0);
    run_mix(120);
    settle_inputs();
    set_queue_mode(1'b1);
    run_mix(50);
    settle_inputs();
    set_queue_mode(1'b0);
    run_mix(50);
    settle_inputs();

    // Give any stray result time to show up.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", awaited_results.size()));
    end

    $display("Run covered %0d transactions (%0d in queue mode) and %0d results.",
             n_items, n_queue_items, n_results);
    $display("Pushes refused on a full store: %0d; longest print-all walk: %0d entries.",
             n_full_refused, longest_walk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d failures in total.", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d results still awaited.", awaited_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
